// File: design/round_robin_thread_scheduler_core_assert.svh
// assertion macros for the round robin thread scheduler
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler port check failed");

// next-cycle implication
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler port check failed");

`endif

// File: design/rrts_pkg.sv
// shared types and constants of the round robin thread scheduler
package rrts_pkg;

   localparam int THREAD_SLOTS    = 16;
   localparam int PROCESS_SLOTS   = 8;
   localparam int EVENT_DEPTH_DEF = 16;
   localparam int THREAD_W        = 4;
   localparam int PROC_W          = 3;
   localparam int RQ_CNT_W        = $clog2(THREAD_SLOTS + 1);
   localparam logic [7:0] TICK_RESET = 8'd2;

   localparam logic [1:0] POL_EVENT_ONLY = 2'd1;
   localparam logic [1:0] POL_BUSY       = 2'd2;

   typedef enum logic [3:0] {
      OP_TICK        = 4'd0,
      OP_SWITCH      = 4'd1,
      OP_RETURN      = 4'd2,
      OP_ADD         = 4'd3,
      OP_KILL_THREAD = 4'd4,
      OP_KILL_PROC   = 4'd5,
      OP_POST        = 4'd6,
      OP_SET_STATE   = 4'd7,
      OP_SET_PROC    = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      KIND_EVENT  = 3'd0,
      KIND_SELECT = 3'd1,
      KIND_IDLE   = 3'd2,
      KIND_ACK    = 3'd3,
      KIND_DROP   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVENTS,
      S_RUNQ
   } state_type;

   typedef struct packed {
      op_type        operation;
      logic [3:0]    thread_slot;
      logic [2:0]    process_slot;
      logic [1:0]    policy;
      logic          is_main;
      logic          parked_flag;
      logic          suspended_flag;
      logic [31:0]   wake_time;
      logic [31:0]   event_code;
      logic [31:0]   event_payload;
      logic          event_busy_flag;
   } req_type;

   typedef struct packed {
      kind_type      kind;
      logic [3:0]    out_thread;
      logic [31:0]   out_event_code;
      logic [31:0]   out_event_payload;
      logic          last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic              main;
      logic [1:0]        policy;
      logic              parked;
      logic              susp;
      logic              evbusy;
      logic [PROC_W-1:0] proc;
   } slot_type;

   typedef struct packed {
      logic [THREAD_W-1:0] thread;
      logic [31:0]         code;
      logic [31:0]         data;
   } ev_type;

endpackage

// File: design/rrts_ram.sv
// simple dual port synchronous memory with registered read
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/round_robin_thread_scheduler_core.sv
// round robin thread scheduler: slot table, run queue memory, event queue memory
// tick, add, post, set, return and kill of an invalid thread: one beat, never busy.
// switch and kill: busy while passing the pending events, then the run queue entries;
// final beat on a pick or at the end; one memory read per cycle per pass.
// reset (synchronous): all slots invalid, both queues empty, nothing running,
// elapsed zero, tick increment 2; no clearing pass. results cannot be stalled.
module round_robin_thread_scheduler_core #(
   parameter int EVENT_DEPTH = rrts_pkg::EVENT_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrts_pkg::req_type req_item,
   output logic              rsp_valid,
   output rrts_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   import rrts_pkg::*;

   localparam int EIW = $clog2(EVENT_DEPTH);
   localparam int ECW = $clog2(EVENT_DEPTH + 1);

   state_type state_ff, state_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [7:0] tick_inc_ff;
   slot_type slots_ff [THREAD_SLOTS];
   slot_type slots_in [THREAD_SLOTS];
   logic [31:0] wake_ff [THREAD_SLOTS];
   logic [31:0] wake_in [THREAD_SLOTS];
   logic [PROCESS_SLOTS-1:0] psusp_ff, psusp_in;
   logic [THREAD_W-1:0] running_ff, running_in;
   logic run_valid_ff, run_valid_in;
   logic [THREAD_W-1:0] rq_head_ff, rq_head_in;
   logic [RQ_CNT_W-1:0] rq_count_ff, rq_count_in;
   logic [ECW-1:0] ev_count_ff, ev_count_in;
   logic is_switch_ff, is_switch_in;
   logic [THREAD_SLOTS-1:0] mask_ff, mask_in;
   logic [ECW-1:0] ev_rd_ff, ev_rd_in, ev_wr_ff, ev_wr_in;
   logic [RQ_CNT_W-1:0] rq_rd_ff, rq_rd_in, rq_wr_ff, rq_wr_in;
   logic dv_ff, dv_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic rq_we;
   logic [THREAD_W-1:0] rq_waddr, rq_wdata, rq_raddr, rq_rdata;
   logic ev_we;
   logic [EIW-1:0] ev_waddr, ev_raddr;
   ev_type ev_wdata, ev_rdata;

   logic accept, go_pass, ev_end, rq_end, rq_pick, rq_elig, cur_valid;
   slot_type rq_f;

   rrts_ram #(.WIDTH(THREAD_W), .DEPTH(THREAD_SLOTS)) u_runq (
      .clock(clock), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
      .raddr(rq_raddr), .rdata(rq_rdata)
   );

   rrts_ram #(.WIDTH($bits(ev_type)), .DEPTH(EVENT_DEPTH)) u_evq (
      .clock(clock), .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
      .raddr(ev_raddr), .rdata(ev_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign cur_valid = slots_ff[req_item.thread_slot].valid;
   assign go_pass   = accept && ((req_item.operation == OP_SWITCH) ||
                      (req_item.operation == OP_KILL_PROC) ||
                      ((req_item.operation == OP_KILL_THREAD) && cur_valid));
   assign ev_end    = !dv_ff && (ev_rd_ff == ev_count_ff);
   assign rq_end    = !dv_ff && (rq_rd_ff == rq_count_ff);

   // eligibility of the run queue entry in the data stage
   always_comb begin
      rq_f    = slots_ff[rq_rdata];
      rq_elig = !((rq_f.policy == POL_EVENT_ONLY) && !rq_f.evbusy) &&
                !psusp_ff[rq_f.proc] && !rq_f.parked &&
                (!rq_f.susp || ((wake_ff[rq_rdata] != 32'd0) &&
                                (wake_ff[rq_rdata] <= elapsed_ff)));
   end

   assign rq_pick = dv_ff && is_switch_ff && rq_elig;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (go_pass) begin
               state_in = S_EVENTS;
            end
         end
         S_EVENTS: begin
            if (ev_end) begin
               state_in = S_RUNQ;
            end
         end
         S_RUNQ: begin
            if (rq_pick || rq_end) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ev_type e;
      slot_type f;
      logic [THREAD_SLOTS-1:0] kmask;
      logic keep;

      e = ev_rdata;
      f = slots_ff[ev_rdata.thread];
      kmask = '0;
      keep = 1'b0;

      elapsed_in   = elapsed_ff;
      slots_in     = slots_ff;
      wake_in      = wake_ff;
      psusp_in     = psusp_ff;
      running_in   = running_ff;
      run_valid_in = run_valid_ff;
      rq_head_in   = rq_head_ff;
      rq_count_in  = rq_count_ff;
      ev_count_in  = ev_count_ff;
      is_switch_in = is_switch_ff;
      mask_in      = mask_ff;
      ev_rd_in     = ev_rd_ff;
      ev_wr_in     = ev_wr_ff;
      rq_rd_in     = rq_rd_ff;
      rq_wr_in     = rq_wr_ff;
      dv_in        = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      rq_we    = 1'b0;
      rq_waddr = rq_head_ff + rq_count_ff[THREAD_W-1:0];
      rq_wdata = running_ff;
      rq_raddr = rq_head_ff + rq_rd_ff[THREAD_W-1:0];
      ev_we    = 1'b0;
      ev_waddr = ev_count_ff[EIW-1:0];
      ev_wdata = '{thread: req_item.thread_slot, code: req_item.event_code,
                   data: req_item.event_payload};
      ev_raddr = ev_rd_ff[EIW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = !go_pass;
               rsp_in = '{kind: KIND_ACK, out_thread: '0, out_event_code: '0,
                          out_event_payload: '0, last: 1'b1};
               is_switch_in = 1'b0;
               ev_rd_in = '0;
               ev_wr_in = '0;
               case (req_item.operation)
                  OP_TICK: begin
                     elapsed_in = elapsed_ff + {24'd0, tick_inc_ff};
                  end
                  OP_SWITCH, OP_RETURN: begin
                     is_switch_in = 1'b1;
                     if (run_valid_ff && (rq_count_ff < RQ_CNT_W'(THREAD_SLOTS))) begin
                        rq_we = 1'b1;
                        rq_count_in = rq_count_ff + 1'b1;
                     end
                     run_valid_in = 1'b0;
                  end
                  OP_ADD: begin
                     if (!cur_valid) begin
                        slots_in[req_item.thread_slot] = '{valid: 1'b1,
                           main: req_item.is_main, policy: req_item.policy,
                           parked: 1'b0, susp: 1'b0, evbusy: 1'b0,
                           proc: req_item.process_slot};
                        wake_in[req_item.thread_slot] = '0;
                        if (rq_count_ff < RQ_CNT_W'(THREAD_SLOTS)) begin
                           rq_we = 1'b1;
                           rq_wdata = req_item.thread_slot;
                           rq_count_in = rq_count_ff + 1'b1;
                        end
                     end
                  end
                  OP_KILL_THREAD, OP_KILL_PROC: begin
                     if (req_item.operation == OP_KILL_PROC) begin
                        for (int i = 0; i < THREAD_SLOTS; i++) begin
                           kmask[i] = slots_ff[i].valid &&
                                      (slots_ff[i].proc == req_item.process_slot);
                        end
                        psusp_in[req_item.process_slot] = 1'b0;
                     end else if (slots_ff[req_item.thread_slot].main) begin
                        for (int i = 0; i < THREAD_SLOTS; i++) begin
                           kmask[i] = slots_ff[i].valid && (slots_ff[i].proc ==
                                      slots_ff[req_item.thread_slot].proc);
                        end
                        psusp_in[slots_ff[req_item.thread_slot].proc] = 1'b0;
                     end else begin
                        kmask[req_item.thread_slot] = cur_valid;
                     end
                     mask_in = kmask;
                     for (int i = 0; i < THREAD_SLOTS; i++) begin
                        if (kmask[i]) begin
                           slots_in[i] = '0;
                           wake_in[i] = '0;
                        end
                     end
                     if (run_valid_ff && kmask[running_ff]) begin
                        run_valid_in = 1'b0;
                     end
                  end
                  OP_POST: begin
                     if (cur_valid) begin
                        if (ev_count_ff == ECW'(EVENT_DEPTH)) begin
                           rsp_in.kind = KIND_DROP;
                           rsp_in.out_thread = req_item.thread_slot;
                        end else begin
                           ev_we = 1'b1;
                           ev_count_in = ev_count_ff + 1'b1;
                        end
                     end
                  end
                  OP_SET_STATE: begin
                     if (cur_valid) begin
                        slots_in[req_item.thread_slot].parked = req_item.parked_flag;
                        slots_in[req_item.thread_slot].susp = req_item.suspended_flag;
                        slots_in[req_item.thread_slot].evbusy = req_item.event_busy_flag;
                        wake_in[req_item.thread_slot] = req_item.wake_time;
                     end
                  end
                  OP_SET_PROC: begin
                     psusp_in[req_item.process_slot] = req_item.suspended_flag;
                  end
                  default: begin
                  end
               endcase
               if (req_item.operation == OP_RETURN) begin
                  is_switch_in = 1'b0;
               end
            end
         end

         S_EVENTS: begin
            if (ev_rd_ff < ev_count_ff) begin
               ev_rd_in = ev_rd_ff + 1'b1;
               dv_in = 1'b1;
            end
            if (dv_ff) begin
               if (!is_switch_ff) begin
                  keep = !mask_ff[e.thread];
               end else if (f.evbusy) begin
                  keep = 1'b1;
               end else if (f.policy != POL_BUSY) begin
                  slots_in[e.thread].parked = 1'b0;
                  slots_in[e.thread].evbusy = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in = '{kind: KIND_EVENT, out_thread: e.thread,
                             out_event_code: e.code, out_event_payload: e.data,
                             last: 1'b0};
               end
               if (keep) begin
                  ev_we = 1'b1;
                  ev_waddr = ev_wr_ff[EIW-1:0];
                  ev_wdata = e;
                  ev_wr_in = ev_wr_ff + 1'b1;
               end
            end
            if (ev_end) begin
               ev_count_in = ev_wr_ff;
               rq_rd_in = '0;
               rq_wr_in = '0;
               dv_in = 1'b0;
            end
         end

         S_RUNQ: begin
            if (rq_rd_ff < rq_count_ff) begin
               rq_rd_in = rq_rd_ff + 1'b1;
               dv_in = 1'b1;
            end
            rsp_in = '{kind: KIND_ACK, out_thread: '0, out_event_code: '0,
                       out_event_payload: '0, last: 1'b1};
            if (rq_pick) begin
               if (rq_f.susp) begin
                  slots_in[rq_rdata].susp = 1'b0;
                  wake_in[rq_rdata] = '0;
               end
               running_in = rq_rdata;
               run_valid_in = 1'b1;
               rq_head_in = rq_head_ff + rq_rd_ff[THREAD_W-1:0];
               rq_count_in = rq_count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.kind = KIND_SELECT;
               rsp_in.out_thread = rq_rdata;
            end else if (dv_ff) begin
               if (is_switch_ff || !mask_ff[rq_rdata]) begin
                  rq_we = 1'b1;
                  rq_waddr = rq_head_ff + rq_count_ff[THREAD_W-1:0] +
                             rq_wr_ff[THREAD_W-1:0];
                  rq_wdata = rq_rdata;
                  rq_wr_in = rq_wr_ff + 1'b1;
               end
            end else if (rq_end) begin
               rq_head_in = rq_head_ff + rq_count_ff[THREAD_W-1:0];
               rq_count_in = rq_wr_ff;
               rsp_valid_in = 1'b1;
               if (is_switch_ff) begin
                  rsp_in.kind = KIND_IDLE;
               end
            end
         end

         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         elapsed_ff   <= '0;
         tick_inc_ff  <= TICK_RESET;
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            slots_ff[i] <= '0;
            wake_ff[i]  <= '0;
         end
         psusp_ff     <= '0;
         run_valid_ff <= 1'b0;
         rq_head_ff   <= '0;
         rq_count_ff  <= '0;
         ev_count_ff  <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         if (csr_wr_en) begin
            tick_inc_ff <= csr_wr_data;
         end
         slots_ff     <= slots_in;
         wake_ff      <= wake_in;
         psusp_ff     <= psusp_in;
         run_valid_ff <= run_valid_in;
         rq_head_ff   <= rq_head_in;
         rq_count_ff  <= rq_count_in;
         ev_count_ff  <= ev_count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      running_ff   <= running_in;
      is_switch_ff <= is_switch_in;
      mask_ff      <= mask_in;
      ev_rd_ff     <= ev_rd_in;
      ev_wr_ff     <= ev_wr_in;
      rq_rd_ff     <= rq_rd_in;
      rq_wr_ff     <= rq_wr_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: design/rrts_checker.sv
// port level checks of the scheduler and their bind
`include "round_robin_thread_scheduler_core_assert.svh"

module rrts_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input rrts_pkg::rsp_type rsp_item
);

   import rrts_pkg::*;

   // an accepted command either answers at once or goes busy
   `RRTS_ASSERT_NEXT(a_accept_reacts, start && !busy, busy || rsp_valid)

   // the closing beat leaves the block ready
   `RRTS_ASSERT_NOW(a_last_idle, rsp_valid && rsp_item.last, !busy)

   // non-final beats are delivered events inside a switch
   `RRTS_ASSERT_NOW(a_mid_event, rsp_valid && !rsp_item.last,
                    busy && (rsp_item.kind == KIND_EVENT))

   // no beat without a command
   `RRTS_ASSERT_NEXT(a_no_spurious, !busy && !start, !rsp_valid)

endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (.*);
